/* design/i2r_pkg.sv */
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, constants and digit-shape functions for the integer to
// Roman numeral converter.
// ----------------------------------------------------------------------------
package i2r_pkg;

  localparam int VALUE_W   = 13;
  localparam int CHAR_W    = 8;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  localparam logic [VALUE_W-1:0] MAX_VALUE = 13'd4999;
  localparam logic [VALUE_W-1:0] THOU      = 13'd1000;
  localparam logic [9:0]         HUND      = 10'd100;
  localparam logic [6:0]         TENS      = 7'd10;

  // output phases: thousands, hundreds, tens, ones
  localparam logic [1:0] PH_THO = 2'd0;
  localparam logic [1:0] PH_HUN = 2'd1;
  localparam logic [1:0] PH_TEN = 2'd2;
  localparam logic [1:0] PH_ONE = 2'd3;

  // symbol within a digit
  localparam logic [1:0] SYM_UNIT = 2'd0;
  localparam logic [1:0] SYM_FIVE = 2'd1;
  localparam logic [1:0] SYM_TEN  = 2'd2;

  localparam logic [CHAR_W-1:0] ERR_CHAR = 8'd0;

  typedef struct packed {
    logic       err;
    logic [2:0] th;
    logic [3:0] hun;
    logic [3:0] ten;
    logic [3:0] one;
  } i2r_entry_t;

  // number of letters a decimal digit takes
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    unique case (d)
      4'd1, 4'd5: n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7: n = 3'd3;
      4'd8: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // symbol at position k of a decimal digit's shape
  function automatic logic [1:0] digit_sym(input logic [3:0] d, input logic [1:0] k);
    logic [1:0] s;
    s = SYM_UNIT;
    if (d == 4'd4 && k == 2'd1) begin
      s = SYM_FIVE;
    end else if (d == 4'd9 && k == 2'd1) begin
      s = SYM_TEN;
    end else if (d >= 4'd5 && d <= 4'd8 && k == 2'd0) begin
      s = SYM_FIVE;
    end
    return s;
  endfunction

  function automatic logic [CHAR_W-1:0] letter(input logic [1:0] ph, input logic [1:0] sym);
    logic [CHAR_W-1:0] c;
    c = "M";
    unique case (ph)
      PH_THO: c = "M";
      PH_HUN: c = (sym == SYM_UNIT) ? "C" : (sym == SYM_FIVE) ? "D" : "M";
      PH_TEN: c = (sym == SYM_UNIT) ? "X" : (sym == SYM_FIVE) ? "L" : "C";
      PH_ONE: c = (sym == SYM_UNIT) ? "I" : (sym == SYM_FIVE) ? "V" : "X";
      default: c = "M";
    endcase
    return c;
  endfunction

endpackage

/* design/i2r_if.sv */
// ----------------------------------------------------------------------------
// i2r_in_if / i2r_out_if
// Valid/ready channels carrying input values and numeral characters.
// ----------------------------------------------------------------------------
interface i2r_in_if;
  logic                         valid;
  logic                         ready;
  logic [i2r_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2r_out_if;
  logic                         valid;
  logic                         ready;
  logic [i2r_pkg::CHAR_W-1:0]   char_code;
  logic                         last;
  logic                         error;

  modport source (output valid, output char_code, output last, output error, input ready);
  modport sink   (input valid, input char_code, input last, input error, output ready);
endinterface

/* design/i2r_front.sv */
// ----------------------------------------------------------------------------
// i2r_front
// Three-stage intake: range check and thousands, then hundreds, then tens
// and ones. Produces one decoded entry per request.
// ----------------------------------------------------------------------------
module i2r_front (
  input  logic                clk,
  input  logic                rst_n,
  i2r_in_if.sink              in_ch,
  output logic                push,
  output i2r_pkg::i2r_entry_t push_data,
  input  logic                q_full
);
  import i2r_pkg::*;

  logic       en;
  logic       s1_v_r, s2_v_r, s3_v_r;
  logic       s1_err_r, s2_err_r;
  logic [2:0] s1_th_r, s2_th_r;
  logic [9:0] s1_rem_r;
  logic [3:0] s2_hun_r;
  logic [6:0] s2_rem_r;
  i2r_entry_t s3_ent_r;

  logic       err_nxt;
  logic [2:0] th_nxt;
  logic [9:0] rem1_nxt;
  logic [3:0] hun_nxt;
  logic [6:0] rem2_nxt;
  logic [3:0] ten_nxt;
  logic [3:0] one_nxt;

  assign en          = !s3_v_r || !q_full;
  assign in_ch.ready = en;
  assign push        = s3_v_r && !q_full;
  assign push_data   = s3_ent_r;

  // stage 1: range check and thousands digit
  always_comb begin
    err_nxt = (in_ch.value == '0) || (in_ch.value > MAX_VALUE);
    th_nxt  = 3'd0;
    for (int i = 1; i <= 4; i++) begin
      if (in_ch.value >= VALUE_W'(i) * THOU) th_nxt = 3'(i);
    end
    rem1_nxt = 10'(in_ch.value - VALUE_W'(th_nxt) * THOU);
  end

  // stage 2: hundreds digit
  always_comb begin
    hun_nxt = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (s1_rem_r >= 10'(i) * HUND) hun_nxt = 4'(i);
    end
    rem2_nxt = 7'(s1_rem_r - 10'(hun_nxt) * HUND);
  end

  // stage 3: tens and ones
  always_comb begin
    ten_nxt = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (s2_rem_r >= 7'(i) * TENS) ten_nxt = 4'(i);
    end
    one_nxt = 4'(s2_rem_r - 7'(ten_nxt) * TENS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_err_r     <= err_nxt;
      s1_th_r      <= th_nxt;
      s1_rem_r     <= rem1_nxt;
      s2_err_r     <= s1_err_r;
      s2_th_r      <= s1_th_r;
      s2_hun_r     <= hun_nxt;
      s2_rem_r     <= rem2_nxt;
      s3_ent_r.err <= s2_err_r;
      s3_ent_r.th  <= s2_th_r;
      s3_ent_r.hun <= s2_hun_r;
      s3_ent_r.ten <= ten_nxt;
      s3_ent_r.one <= one_nxt;
    end
  end

endmodule

/* design/i2r_fifo.sv */
// ----------------------------------------------------------------------------
// i2r_fifo
// Short queue of decoded entries between intake and character sequencer.
// ----------------------------------------------------------------------------
module i2r_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  i2r_pkg::i2r_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output i2r_pkg::i2r_entry_t q_data
);
  import i2r_pkg::*;

  i2r_entry_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]    cnt_r;

  assign full    = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
`endif

endmodule

/* design/i2r_back.sv */
// ----------------------------------------------------------------------------
// i2r_back
// Character sequencer: walks the phases of one entry and emits one numeral
// letter per cycle into the output register while it is empty or taken.
// ----------------------------------------------------------------------------
module i2r_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  i2r_pkg::i2r_entry_t q_data,
  output logic                pop,
  i2r_out_if.source           out_ch
);
  import i2r_pkg::*;

  logic              busy_r, busy_nxt;
  i2r_entry_t        ent_r;
  logic [1:0]        ph_r, ph_nxt;
  logic [1:0]        k_r, k_nxt;
  logic              out_valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              last_r, err_r;

  logic [2:0]        lenv [4];
  logic [2:0]        lenq [4];
  logic [2:0]        cur_len;
  logic [3:0]        dsel;
  logic [1:0]        cur_sym;
  logic [CHAR_W-1:0] ch;
  logic              end_dig, any_next, is_last;
  logic [1:0]        nxt_ph, first_ph;
  logic              adv, emit, take;

  always_comb begin
    lenv[0] = ent_r.th;
    lenv[1] = digit_len(ent_r.hun);
    lenv[2] = digit_len(ent_r.ten);
    lenv[3] = digit_len(ent_r.one);
    lenq[0] = q_data.th;
    lenq[1] = digit_len(q_data.hun);
    lenq[2] = digit_len(q_data.ten);
    lenq[3] = digit_len(q_data.one);

    cur_len = lenv[ph_r];
    end_dig = ((3'(k_r) + 3'd1) == cur_len);

    // nearest later phase that has letters
    any_next = 1'b0;
    nxt_ph   = ph_r;
    for (int p = 3; p >= 0; p--) begin
      if (2'(p) > ph_r && lenv[p] != 3'd0) begin
        any_next = 1'b1;
        nxt_ph   = 2'(p);
      end
    end

    first_ph = PH_ONE;
    for (int p = 3; p >= 0; p--) begin
      if (lenq[p] != 3'd0) first_ph = 2'(p);
    end

    unique case (ph_r)
      PH_HUN:  dsel = ent_r.hun;
      PH_TEN:  dsel = ent_r.ten;
      PH_ONE:  dsel = ent_r.one;
      default: dsel = 4'd1;
    endcase
    cur_sym = (ph_r == PH_THO) ? SYM_UNIT : digit_sym(dsel, k_r);
    ch      = ent_r.err ? ERR_CHAR : letter(ph_r, cur_sym);
    is_last = ent_r.err || (end_dig && !any_next);

    adv  = !out_valid_r || out_ch.ready;
    emit = busy_r && adv;
    take = q_valid && (!busy_r || (emit && is_last));
    pop  = take;

    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    k_nxt    = k_r;
    if (take) begin
      busy_nxt = 1'b1;
      ph_nxt   = first_ph;
      k_nxt    = 2'd0;
    end else if (emit && is_last) begin
      busy_nxt = 1'b0;
    end else if (emit) begin
      if (end_dig) begin
        ph_nxt = nxt_ph;
        k_nxt  = 2'd0;
      end else begin
        k_nxt = k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ph_r        <= PH_THO;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      k_r    <= k_nxt;
      if (adv) out_valid_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) ent_r <= q_data;
    if (emit) begin
      char_r <= ch;
      last_r <= is_last;
      err_r  <= ent_r.err;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_code = char_r;
  assign out_ch.last      = last_r;
  assign out_ch.error     = err_r;

`ifndef SYNTHESIS
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r |-> last_r) else $error("error result not marked last");
  a_letter_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !err_r |-> char_r != ERR_CHAR) else $error("empty letter emitted");
  a_pos_in_digit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !ent_r.err |-> 3'(k_r) < cur_len) else $error("position past digit end");
`endif

endmodule

/* design/integer_to_roman_numeral.sv */
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts 13-bit unsigned values to Roman numerals, one ASCII letter per
// result, final letter flagged; 0 and values above 4999 give one error result.
// ----------------------------------------------------------------------------
// A value gives as many output results as its numeral has letters: 1 to 16
// (MMMMDCCCLXXXVIII is the longest); an error value gives one result. The
// character sequencer emits one letter per cycle while the output is ready
// and sets the sustained rate; a three-stage intake pipeline and a two-entry
// queue in front of it keep accepting values while it works. A request goes
// through the intake stages, the queue, the sequencer's entry register and
// the output register before its first letter appears.
module integer_to_roman_numeral (
  input  logic      clk,
  input  logic      rst_n,
  i2r_in_if.sink    in_ch,
  i2r_out_if.source out_ch
);
  import i2r_pkg::*;

  logic       push, full, pop, q_valid;
  i2r_entry_t push_data, q_data;

  i2r_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .q_full    (full)
  );

  i2r_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  i2r_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

/* dv/integer_to_roman_numeral_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_roman_numeral_tb
// Drives 13-bit values into the converter and checks every numeral letter,
// last flag and error flag against a scoreboard that predicts the numeral.
// ----------------------------------------------------------------------------

class roman_scoreboard;

  typedef struct {
    logic [i2r_pkg::CHAR_W-1:0] code;
    logic                       last;
    logic                       error;
  } numeral_char_t;

  numeral_char_t pending_chars[$];
  int mismatches;
  int values_taken;
  int bad_values;
  int chars_checked;

  function new();
    mismatches    = 0;
    values_taken  = 0;
    bad_values    = 0;
    chars_checked = 0;
  endfunction

  function void push_char(logic [i2r_pkg::CHAR_W-1:0] c);
    numeral_char_t e;
    e.code  = c;
    e.last  = 1'b0;
    e.error = 1'b0;
    pending_chars.push_back(e);
  endfunction

  // one decimal digit; unit/five/ten are the letters for its position
  function void push_digit(int d, logic [i2r_pkg::CHAR_W-1:0] unit,
                           logic [i2r_pkg::CHAR_W-1:0] five,
                           logic [i2r_pkg::CHAR_W-1:0] ten);
    if (d == 9) begin
      push_char(unit);
      push_char(ten);
    end else if (d == 4) begin
      push_char(unit);
      push_char(five);
    end else begin
      if (d >= 5) begin
        push_char(five);
      end
      repeat (d % 5) push_char(unit);
    end
  endfunction

  function void note_request(logic [i2r_pkg::VALUE_W-1:0] v);
    numeral_char_t e;
    int n;
    n = int'(v);
    values_taken++;
    if (n == 0 || n > 4999) begin
      bad_values++;
      e.code  = i2r_pkg::ERR_CHAR;
      e.last  = 1'b1;
      e.error = 1'b1;
      pending_chars.push_back(e);
    end else begin
      repeat (n / 1000) push_char("M");
      push_digit((n / 100) % 10, "C", "D", "M");
      push_digit((n / 10) % 10, "X", "L", "C");
      push_digit(n % 10, "I", "V", "X");
      pending_chars[pending_chars.size()-1].last = 1'b1;
    end
  endfunction

  function void check_result(logic [i2r_pkg::CHAR_W-1:0] code, logic last,
                             logic error);
    numeral_char_t e;
    if (pending_chars.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result char=%02h last=%b error=%b",
               $time, code, last, error);
      return;
    end
    e = pending_chars.pop_front();
    chars_checked++;
    if (code !== e.code) begin
      mismatches++;
      $display("%0t: char_code expected %02h actual %02h", $time, e.code, code);
    end
    if (last !== e.last) begin
      mismatches++;
      $display("%0t: last expected %b actual %b", $time, e.last, last);
    end
    if (error !== e.error) begin
      mismatches++;
      $display("%0t: error expected %b actual %b", $time, e.error, error);
    end
  endfunction

endclass

module integer_to_roman_numeral_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_VALUES = 290;
  localparam int VALUE_W = i2r_pkg::VALUE_W;

  logic clk;
  logic rst_n;
  int   idle_cycles;
  int   stall_left;
  int   rx_mode;
  int   rx_mode_cycles;

  roman_scoreboard numeral_sb;

  i2r_in_if  in_ch ();
  i2r_out_if out_ch ();

  integer_to_roman_numeral dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        numeral_sb.note_request(in_ch.value);
      end
      if (out_ch.valid && out_ch.ready) begin
        numeral_sb.check_result(out_ch.char_code, out_ch.last, out_ch.error);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request or result for %0d cycles", $time, IDLE_LIMIT);
        $display("integer_to_roman_numeral regression: fail");
        $finish;
      end
    end
  end

  // receiver: switches between always ready, random ready and long stalls
  always @(negedge clk) begin
    if (rx_mode_cycles == 0) begin
      rx_mode        = $urandom_range(0, 2);
      rx_mode_cycles = $urandom_range(20, 80);
    end
    rx_mode_cycles--;
    if (rx_mode == 0) begin
      out_ch.ready <= 1'b1;
    end else if (rx_mode == 1) begin
      out_ch.ready <= ($urandom_range(0, 3) != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    in_ch.value <= VALUE_W'($urandom_range(0, 8191));
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (numeral_sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      return '0;
    end else if (sel <= 2) begin
      return VALUE_W'($urandom_range(5000, 8191));
    end else if (sel == 3) begin
      return VALUE_W'($urandom_range(4880, 4999));
    end
    // digit by digit, so 4, 8 and 9 digits turn up often
    return VALUE_W'($urandom_range(0, 4) * 1000 + $urandom_range(0, 9) * 100 +
                    $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
  endfunction

  initial begin
    int directed_values[$];
    int sent;
    int burst_len;
    int gap;
    directed_values = '{0, 1, 4, 5, 9, 10, 40, 49, 90, 99, 400, 444, 900,
                        999, 1000, 1994, 3999, 4000, 4888, 4999, 5000, 5001,
                        8191, 3888};
    numeral_sb     = new();
    clk            = 1'b0;
    rst_n          = 1'b0;
    idle_cycles    = 0;
    stall_left     = 0;
    rx_mode        = 0;
    rx_mode_cycles = 0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_values[i]) begin
      send_value(VALUE_W'(directed_values[i]));
    end
    wait_drained();

    sent = 0;
    while (sent < RANDOM_VALUES) begin
      burst_len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(1, 10);
      repeat (burst_len) begin
        send_value(pick_value());
        sent++;
      end
      if (sent >= RANDOM_VALUES / 2 && sent - burst_len < RANDOM_VALUES / 2) begin
        wait_drained();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          hold_off(gap);
        end
      end
    end
    wait_drained();

    $display("%0d values sent (%0d out of range), %0d numeral letters checked",
             numeral_sb.values_taken, numeral_sb.bad_values,
             numeral_sb.chars_checked);
    $display("directed edge values plus random values under bursty input and stalled output");
    if (numeral_sb.mismatches == 0 && numeral_sb.pending_chars.size() == 0) begin
      $display("integer_to_roman_numeral regression: pass");
    end else begin
      if (numeral_sb.pending_chars.size() != 0) begin
        $display("%0t: %0d expected letters never arrived", $time,
                 numeral_sb.pending_chars.size());
      end
      $display("integer_to_roman_numeral regression: fail");
    end
    $finish;
  end

endmodule
